// ===== rtl/core/ukl_pkg.sv =====
// ukl_pkg: shared types and constants for the unique key list table
// no dependencies; used by the channel interfaces and every module of the block
`default_nettype none

package ukl_pkg;

	// fixed field widths of the request and response channels
	localparam int KIND_W = 2;
	localparam int KEY_W  = 64;
	localparam int POS_W  = 5;

	// default table geometry
	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 64;

	// request kinds; the unused code behaves as a lookup
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

	// per-cycle commands from the sequencer to the datapath
	typedef struct packed {
		logic load_key;
		logic rd_en;
		logic wr_en;
		logic wr_from_key;
	} dp_cmd_t;

	// one response item
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] entry_count;
		logic             is_empty;
		logic             is_full;
		logic             dropped;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/ukl_if.sv =====
// ukl_if: request and response channel interfaces with valid/ready handshake
// depends on ukl_pkg for the field widths
`default_nettype none

interface ukl_req_if;
	logic                        valid;
	logic                        ready;
	logic [ukl_pkg::KIND_W-1:0]  kind;
	logic [ukl_pkg::KEY_W-1:0]   key;

	modport source (output valid, output kind, output key, input ready);
	modport sink   (input valid, input kind, input key, output ready);
endinterface

interface ukl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [ukl_pkg::POS_W-1:0]   position;
	logic [ukl_pkg::POS_W-1:0]   entry_count;
	logic                        is_empty;
	logic                        is_full;
	logic                        dropped;

	modport source (output valid, output found, output position, output entry_count,
		output is_empty, output is_full, output dropped, input ready);
	modport sink   (input valid, input found, input position, input entry_count,
		input is_empty, input is_full, input dropped, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ukl_dp.sv =====
// ukl_dp: slot memory, key register, read register and the shared key comparator
// depends on ukl_pkg (dp_cmd_t, KEY_W); driven by ukl_ctrl
`default_nettype none

module ukl_dp #(
	parameter int ENTRIES  = ukl_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = ukl_pkg::KEY_BITS_DEF,
	localparam int IDX_W   = $clog2(ENTRIES)
) (
	input  wire                        clk,
	input  ukl_pkg::dp_cmd_t           cmd,
	input  wire [IDX_W-1:0]            rd_addr,
	input  wire [IDX_W-1:0]            wr_addr,
	input  wire [ukl_pkg::KEY_W-1:0]   in_key,
	output logic                       match
);

	logic [KEY_BITS-1:0] mem [ENTRIES];
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] rd_q;

	// request key, only the low key bits take part
	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= in_key[KEY_BITS-1:0];
		end
	end

	// one registered read port
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// one write port: append the key or move a read entry down
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= cmd.wr_from_key ? key_q : rd_q;
		end
	end

	// shared comparator
	assign match = (rd_q == key_q);

endmodule

`default_nettype wire

// ===== rtl/core/ukl_ctrl.sv =====
// ukl_ctrl: sequencer for search, append and shift-down passes over the slots
// depends on ukl_pkg (kinds, dp_cmd_t, rsp_t); drives ukl_dp
`default_nettype none

module ukl_ctrl #(
	parameter int ENTRIES = ukl_pkg::ENTRIES_DEF,
	localparam int IDX_W  = $clog2(ENTRIES),
	localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire [ukl_pkg::KIND_W-1:0]   kind,
	input  wire                         match,
	input  wire                         out_free,
	output logic                        idle,
	output logic                        done,
	output ukl_pkg::rsp_t               rsp,
	output ukl_pkg::dp_cmd_t            cmd,
	output logic [IDX_W-1:0]            rd_addr,
	output logic [IDX_W-1:0]            wr_addr
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [ukl_pkg::KIND_W-1:0] kind_q;
	logic [CNT_W-1:0]           idx_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           pos_q;
	logic                       found_q;
	logic                       dropped_q;

	logic [CNT_W-1:0] idx_nx;
	logic             is_add;
	logic             is_del;
	logic             in_range;
	logic             has_room;

	assign idx_nx   = idx_q + CNT_W'(1);
	assign is_add   = (kind_q == ukl_pkg::KIND_ADD);
	assign is_del   = (kind_q == ukl_pkg::KIND_DEL);
	assign in_range = (idx_q < cnt_q);
	assign has_room = (cnt_q < CNT_W'(ENTRIES));

	// datapath commands for the current step
	always_comb begin
		cmd             = '0;
		cmd.load_key    = start;
		rd_addr         = idx_q[IDX_W-1:0];
		wr_addr         = idx_q[IDX_W-1:0];
		unique case (state_q)
			ST_SRCH_RD: begin
				if (in_range) begin
					cmd.rd_en = 1'b1;
				end else if (is_add && has_room) begin
					cmd.wr_en       = 1'b1;
					cmd.wr_from_key = 1'b1;
					wr_addr         = cnt_q[IDX_W-1:0];
				end
			end
			ST_SHIFT_RD: begin
				cmd.rd_en = (idx_nx < cnt_q);
				rd_addr   = idx_nx[IDX_W-1:0];
			end
			ST_SHIFT_WR: begin
				cmd.wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kind_q    <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
			pos_q     <= '0;
			found_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q    <= kind;
						idx_q     <= '0;
						found_q   <= 1'b0;
						dropped_q <= 1'b0;
						state_q   <= ST_SRCH_RD;
					end
				end
				// walk the stored entries; past the last one the key is absent
				ST_SRCH_RD: begin
					if (in_range) begin
						state_q <= ST_SRCH_CMP;
					end else begin
						pos_q <= CNT_W'(ENTRIES);
						if (is_add) begin
							if (has_room) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end else begin
								dropped_q <= 1'b1;
							end
						end
						state_q <= ST_DONE;
					end
				end
				ST_SRCH_CMP: begin
					if (match) begin
						found_q <= 1'b1;
						pos_q   <= idx_q;
						state_q <= is_del ? ST_SHIFT_RD : ST_DONE;
					end else begin
						idx_q   <= idx_nx;
						state_q <= ST_SRCH_RD;
					end
				end
				// close the gap one entry at a time
				ST_SHIFT_RD: begin
					if (idx_nx < cnt_q) begin
						state_q <= ST_SHIFT_WR;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= ST_DONE;
					end
				end
				ST_SHIFT_WR: begin
					idx_q   <= idx_nx;
					state_q <= ST_SHIFT_RD;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE) && out_free;

	// result fields, masked to the channel widths
	always_comb begin
		rsp.found       = found_q;
		rsp.position    = ukl_pkg::POS_W'(pos_q);
		rsp.entry_count = ukl_pkg::POS_W'(cnt_q);
		rsp.is_empty    = (cnt_q == '0);
		rsp.is_full     = !has_room;
		rsp.dropped     = dropped_q;
	end

endmodule

`default_nettype wire

// ===== rtl/core/unique_key_list_table_top.sv =====
// unique_key_list_table_top: packed ordered list of unique keys with add, delete, lookup
// depends on ukl_pkg, ukl_if (ukl_req_if, ukl_rsp_if), ukl_ctrl and ukl_dp
//
//  channel | dir | payload                                                  | handshake
//  req     | in  | kind, key                                                | valid/ready
//  rsp     | out | found, position, entry_count, is_empty, is_full, dropped | valid/ready
//
// one request at a time; the slot memory has one read and one write port, and each
// compared slot passes a read state and a compare state, each shifted slot a read and a write state
// arst_n clears the count and the sequencer; slot contents are not cleared
// a finished result waits in the output register; the next request is taken while it waits
`default_nettype none

module unique_key_list_table_top #(
	parameter int ENTRIES  = ukl_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = ukl_pkg::KEY_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	ukl_req_if.sink    req,
	ukl_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(ENTRIES);

	ukl_pkg::dp_cmd_t cmd;
	ukl_pkg::rsp_t    res;
	ukl_pkg::rsp_t    res_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             match;
	logic             idle;
	logic             done;
	logic             start;
	logic             out_free;
	logic             rsp_valid_q;

	assign req.ready = idle;
	assign start     = req.valid && idle;
	assign out_free  = !rsp_valid_q || rsp.ready;

	ukl_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.kind     (req.kind),
		.match    (match),
		.out_free (out_free),
		.idle     (idle),
		.done     (done),
		.rsp      (res),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	ukl_dp #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.in_key  (req.key),
		.match   (match)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = res_q.found;
	assign rsp.position    = res_q.position;
	assign rsp.entry_count = res_q.entry_count;
	assign rsp.is_empty    = res_q.is_empty;
	assign rsp.is_full     = res_q.is_full;
	assign rsp.dropped     = res_q.dropped;

`ifndef SYNTHESIS
	// a refused add only happens on a full table and for an absent key
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.dropped |-> rsp.is_full && !rsp.found)
		else $error("dropped add without full table or with key present");

	// an absent key reports the table size as its position
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.position == ukl_pkg::POS_W'(ENTRIES))
		else $error("absent key with a slot position");

	// a transfer on the request side starts a pass; no new request is taken while it runs
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while the previous one is in progress");

	// a new result is loaded only when the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !rsp_valid_q || rsp.ready)
		else $error("result overwrote a pending response");
`endif

endmodule

`default_nettype wire
